FILE: rtl/core/frac_red_pkg.sv
// Shared widths, payload structs and control/status structs for the fraction reducer.
package frac_red_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_WIDTH = 32;
    localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [FIELD_WIDTH-1:0] field_t;
    typedef logic [SHIFT_WIDTH-1:0] shift_t;
    typedef logic [CNT_WIDTH-1:0]   count_t;

    typedef struct packed {
        field_t numerator_in;
        field_t denominator_in;
    } in_t;

    typedef struct packed {
        field_t numerator_out;
        field_t denominator_out;
    } out_t;

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic gcd_done;
    } status_t;

    function automatic value_t to_value(input field_t f);
        logic [63:0] wide;
        wide = 64'(f);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    function automatic field_t to_field(input value_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[FIELD_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/core/frac_red_dp.sv
// Datapath: binary GCD unit, two restoring dividers and the result register.
module frac_red_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  frac_red_pkg::in_t      s_data,
    input  frac_red_pkg::cmd_t     cmd,
    output frac_red_pkg::status_t  status,
    output frac_red_pkg::out_t     m_data
);

    typedef struct packed {
        frac_red_pkg::value_t rem;
        frac_red_pkg::value_t quo;
    } div_t;

    // One restoring step: dividend bits shift out of quo, quotient bits shift in.
    function automatic div_t div_iter(input frac_red_pkg::value_t rem,
                                      input frac_red_pkg::value_t quo,
                                      input frac_red_pkg::value_t dvs);
        logic [frac_red_pkg::VALUE_WIDTH:0] shifted;
        logic [frac_red_pkg::VALUE_WIDTH:0] diff;
        div_t                               res;
        shifted = {rem, quo[frac_red_pkg::VALUE_WIDTH-1]};
        diff    = shifted - {1'b0, dvs};
        if (!diff[frac_red_pkg::VALUE_WIDTH]) begin
            res.rem = diff[frac_red_pkg::VALUE_WIDTH-1:0];
            res.quo = {quo[frac_red_pkg::VALUE_WIDTH-2:0], 1'b1};
        end else begin
            res.rem = shifted[frac_red_pkg::VALUE_WIDTH-1:0];
            res.quo = {quo[frac_red_pkg::VALUE_WIDTH-2:0], 1'b0};
        end
        return res;
    endfunction

    frac_red_pkg::value_t a_reg, a_next;
    frac_red_pkg::value_t b_reg, b_next;
    frac_red_pkg::shift_t k_reg, k_next;
    frac_red_pkg::value_t g_reg, g_next;
    frac_red_pkg::value_t nq_reg, nq_next;
    frac_red_pkg::value_t nr_reg, nr_next;
    frac_red_pkg::value_t dq_reg, dq_next;
    frac_red_pkg::value_t dr_reg, dr_next;
    logic                 bypass_reg, bypass_next;
    frac_red_pkg::out_t   out_reg, out_next;

    frac_red_pkg::value_t num_in, den_in;
    div_t                 num_div, den_div;

    assign num_in = frac_red_pkg::to_value(s_data.numerator_in);
    assign den_in = frac_red_pkg::to_value(s_data.denominator_in);

    assign num_div = div_iter(nr_reg, nq_reg, g_reg);
    assign den_div = div_iter(dr_reg, dq_reg, g_reg);

    assign status.bypass   = bypass_reg;
    assign status.gcd_done = (a_reg == '0);
    assign m_data          = out_reg;

    always_comb begin
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        g_next      = g_reg;
        nq_next     = nq_reg;
        nr_next     = nr_reg;
        dq_next     = dq_reg;
        dr_next     = dr_reg;
        bypass_next = bypass_reg;
        out_next    = out_reg;

        if (cmd.load) begin
            a_next      = num_in;
            b_next      = den_in;
            k_next      = '0;
            nq_next     = num_in;
            dq_next     = den_in;
            bypass_next = (den_in < frac_red_pkg::value_t'(2));
        end

        if (cmd.gcd_step) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + frac_red_pkg::shift_t'(1);
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_reg >= b_reg) begin
                a_next = a_reg - b_reg;
            end else begin
                b_next = b_reg - a_reg;
            end
        end

        if (cmd.div_start) begin
            g_next  = b_reg << k_reg;
            nr_next = '0;
            dr_next = '0;
        end

        if (cmd.div_step) begin
            nr_next = num_div.rem;
            nq_next = num_div.quo;
            dr_next = den_div.rem;
            dq_next = den_div.quo;
        end

        if (cmd.commit) begin
            out_next.numerator_out   = frac_red_pkg::to_field(nq_reg);
            out_next.denominator_out = frac_red_pkg::to_field(dq_reg);
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        g_reg   <= g_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
        dq_reg  <= dq_next;
        dr_reg  <= dr_next;
        out_reg <= out_next;
        if (!aresetn) begin
            bypass_reg <= 1'b0;
        end else begin
            bypass_reg <= bypass_next;
        end
    end

    // odd b never drops to zero through a GCD step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.gcd_step && !bypass_reg) |=> (b_reg != '0))
        else $error("GCD step cleared b");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (g_reg != '0))
        else $error("zero divisor loaded");

endmodule

FILE: rtl/core/frac_red_ctrl.sv
// Controller: sequences load, GCD, division and result commit.
module frac_red_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  frac_red_pkg::status_t  status,
    output frac_red_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t               state_reg, state_next;
    frac_red_pkg::count_t cnt_reg, cnt_next;
    logic                 valid_reg, valid_next;
    logic                 out_free;

    assign out_free = !valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (status.bypass) begin
                    state_next = ST_HOLD;
                end else if (status.gcd_done) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = frac_red_pkg::count_t'(frac_red_pkg::VALUE_WIDTH - 1);
                    state_next    = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_HOLD;
                end else begin
                    cnt_next = cnt_reg - frac_red_pkg::count_t'(1);
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!valid_reg || m_ready))
        else $error("result register overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != '0) |=> (state_reg == ST_DIV))
        else $error("division left early");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_GCD && !s_ready))
        else $error("load did not start GCD");

endmodule

FILE: rtl/core/fraction_reducer_unit.sv
// Fraction reducer top level: binary GCD then two parallel restoring divisions.
// Sequence: load, binary GCD steps (one per cycle), restoring division steps and commit.
// Denominator 0 or 1 skips GCD and division. One transaction at a time, set by the
// single subtract/shift GCD unit; a result may wait while the next is taken.
// Reset is synchronous, active low, and clears the controller and output valid.
module fraction_reducer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  frac_red_pkg::in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output frac_red_pkg::out_t  m_data
);

    frac_red_pkg::cmd_t    cmd;
    frac_red_pkg::status_t status;

    frac_red_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    frac_red_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
